/* rtl/stochastic_log_level_quantizer_assert.svh */
// Assertion macros for the log-level quantizer.
`ifndef STOCHASTIC_LOG_LEVEL_QUANTIZER_ASSERT_SVH
`define STOCHASTIC_LOG_LEVEL_QUANTIZER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SLQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slq assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SLQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slq assertion failed");

`endif

/* rtl/slq_pkg.sv */
// Types, constants and level functions of the log-level quantizer.
`default_nettype none

package slq_pkg;

  localparam int LEVELS  = 16;
  localparam int HALF_LV = LEVELS / 2;
  localparam int TOP_EXP = HALF_LV - 1;
  localparam int NUM_TH  = LEVELS - 1;

  localparam int CODE_W  = 4;
  localparam int VAL_W   = 32;
  localparam int NORM_W  = 31;
  localparam int DRAW_W  = 20;
  localparam int EXP_W   = 3;
  localparam int WIDE_W  = VAL_W + TOP_EXP + 2;
  localparam int GAP_W   = WIDE_W - 1;
  localparam int PROD_W  = NORM_W + DRAW_W;
  localparam int CMP_W   = GAP_W + DRAW_W;

  localparam logic [DRAW_W-1:0] DRAW_ONE = DRAW_W'(1000000);
  localparam logic [CODE_W-1:0] CODE_TOP = CODE_W'(LEVELS - 1);
  localparam logic [CODE_W-1:0] CODE_BOT = '0;

  typedef enum logic {
    CMD_QUANT   = 1'b0,
    CMD_DEQUANT = 1'b1
  } slq_cmd_e;

  typedef struct packed {
    slq_cmd_e                  cmd;
    logic signed [VAL_W-1:0]   grad_value;
    logic [NORM_W-1:0]         bucket_norm;
    logic [DRAW_W-1:0]         random_draw;
    logic [CODE_W-1:0]         level_code;
    logic                      last_in;
  } slq_in_t;

  typedef struct packed {
    logic [CODE_W-1:0]         code_out;
    logic signed [VAL_W-1:0]   value_out;
    logic                      last_out;
  } slq_out_t;

  typedef struct packed {
    slq_cmd_e                  cmd;
    logic                      last;
    logic                      zero_norm;
    logic                      grad_nonneg;
    logic                      top_hit;
    logic [CODE_W-1:0]         base_code;
    logic [EXP_W-1:0]          diff_exp;
    logic [GAP_W-1:0]          gap;
    logic [PROD_W-1:0]         prod;
    logic [VAL_W-1:0]          deq_value;
  } slq_mid_t;

  // Threshold i lies at level i: sign and power-of-two exponent (scaled by 2^TOP_EXP).
  function automatic logic th_neg(int i);
    return (i < HALF_LV);
  endfunction

  function automatic logic [EXP_W-1:0] th_exp(int i);
    logic [EXP_W-1:0] e;
    if (i < HALF_LV) begin
      e = EXP_W'(TOP_EXP - i);
    end else begin
      e = EXP_W'(i - HALF_LV);
    end
    return e;
  endfunction

  // Exponent of the gap between level j+1 and level j.
  function automatic logic [EXP_W-1:0] gap_exp(logic [CODE_W-1:0] j);
    logic [EXP_W-1:0] e;
    if (int'(j) < HALF_LV - 1) begin
      e = EXP_W'(TOP_EXP - 1 - int'(j));
    end else if (int'(j) == HALF_LV - 1) begin
      e = EXP_W'(1);
    end else begin
      e = EXP_W'(int'(j) - HALF_LV);
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/slq_search.sv */
// Interval search, rounding operands and dequantize value, registered.
`default_nettype none

module slq_search (
  input  logic             clk_i,
  input  logic             en_i,
  input  slq_pkg::slq_in_t in_i,
  output slq_pkg::slq_mid_t mid_o
);
  import slq_pkg::*;

  logic signed [WIDE_W-1:0] ys;
  logic signed [WIDE_W-1:0] norm_w;
  logic signed [WIDE_W-1:0] bound [NUM_TH];
  logic [NUM_TH-1:0]        above;
  logic [CODE_W-1:0]        cnt;
  logic                     top_hit;
  logic signed [WIDE_W-1:0] bsel;
  logic signed [WIDE_W-1:0] gap_w;
  logic [DRAW_W-1:0]        draw_sat;
  logic [VAL_W-1:0]         norm_shr;
  logic [VAL_W-1:0]         deq;
  slq_mid_t                 mid_d, mid_q;

  assign ys     = $signed(WIDE_W'(in_i.grad_value)) <<< TOP_EXP;
  assign norm_w = $signed(WIDE_W'(in_i.bucket_norm));

  always_comb begin
    for (int k = 0; k < NUM_TH; k++) begin
      bound[k] = th_neg(k + 1) ? -(norm_w <<< th_exp(k + 1)) : (norm_w <<< th_exp(k + 1));
      above[k] = (ys > bound[k]);
    end
  end

  assign cnt     = CODE_W'($countones(above));
  assign top_hit = (int'(cnt) == NUM_TH);
  assign bsel    = top_hit ? '0 : bound[cnt];
  assign gap_w   = bsel - ys;

  assign draw_sat = (in_i.random_draw > DRAW_ONE) ? DRAW_ONE : in_i.random_draw;

  always_comb begin
    if (int'(in_i.level_code) < HALF_LV) begin
      norm_shr = VAL_W'(in_i.bucket_norm >> in_i.level_code);
      deq      = '0 - norm_shr;
    end else begin
      norm_shr = VAL_W'(in_i.bucket_norm >> (CODE_TOP - in_i.level_code));
      deq      = norm_shr;
    end
  end

  always_comb begin
    mid_d.cmd         = in_i.cmd;
    mid_d.last        = in_i.last_in;
    mid_d.zero_norm   = (in_i.bucket_norm == '0);
    mid_d.grad_nonneg = !in_i.grad_value[VAL_W-1];
    mid_d.top_hit     = top_hit;
    mid_d.base_code   = cnt;
    mid_d.diff_exp    = gap_exp(cnt);
    mid_d.gap         = gap_w[GAP_W-1:0];
    mid_d.prod        = PROD_W'(in_i.bucket_norm) * PROD_W'(draw_sat);
    mid_d.deq_value   = deq;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

`default_nettype wire

/* rtl/slq_round.sv */
// Stochastic rounding decision and result register.
`default_nettype none

module slq_round (
  input  logic              clk_i,
  input  logic              en_i,
  input  slq_pkg::slq_mid_t mid_i,
  output slq_pkg::slq_out_t out_o
);
  import slq_pkg::*;

  logic [CMP_W-1:0]  lhs;
  logic [CMP_W-1:0]  rhs;
  logic              round_up;
  logic [CODE_W-1:0] code;
  slq_out_t          out_d, out_q;

  assign lhs      = CMP_W'(mid_i.prod) << mid_i.diff_exp;
  assign rhs      = CMP_W'(mid_i.gap) * CMP_W'(DRAW_ONE);
  assign round_up = (lhs > rhs);

  always_comb begin
    if (mid_i.zero_norm) begin
      code = mid_i.grad_nonneg ? CODE_TOP : CODE_BOT;
    end else if (mid_i.top_hit) begin
      code = CODE_TOP;
    end else begin
      code = mid_i.base_code + CODE_W'(round_up);
    end
  end

  always_comb begin
    out_d.last_out = mid_i.last;
    if (mid_i.cmd == CMD_DEQUANT) begin
      out_d.code_out  = '0;
      out_d.value_out = $signed(mid_i.deq_value);
    end else begin
      out_d.code_out  = code;
      out_d.value_out = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

/* rtl/stochastic_log_level_quantizer.sv */
// Top level of the stochastic log-level gradient quantizer.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_ready_o    | in_data_i  (slq_in_t)
//   out     | output    | out_valid_o / out_ready_i  | out_data_o (slq_out_t)
//
// One transaction per cycle sustained while out_ready_i is high.
// out_valid_o rises once an accepted transaction has passed through the
// input register, search register and result register, in that order.
// Reset clears the three stage valid bits only.
// A stall at the output backs up stage by stage; empty stages still fill.
`default_nettype none
`include "stochastic_log_level_quantizer_assert.svh"

module stochastic_log_level_quantizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  slq_pkg::slq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slq_pkg::slq_out_t out_data_o
);
  import slq_pkg::*;

  logic      v1_q, v2_q, v3_q;
  logic      en1, en2, en3;
  logic      in_acc, out_acc;
  slq_in_t   in_q;
  slq_mid_t  mid;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  slq_search u_search (
    .clk_i (clk_i),
    .en_i  (en2 && v1_q),
    .in_i  (in_q),
    .mid_o (mid)
  );

  slq_round u_round (
    .clk_i (clk_i),
    .en_i  (en3 && v2_q),
    .mid_i (mid),
    .out_o (out_data_o)
  );

  `SLQ_ASSERT_NEXT(a_occupancy, 1'b1, $countones({v1_q, v2_q, v3_q}) == $past($countones({v1_q, v2_q, v3_q})) + $past(int'(in_acc)) - $past(int'(out_acc)))
  `SLQ_ASSERT_NEXT(a_mid_hold, v2_q && !en3, $stable(mid))
  `SLQ_ASSERT_NEXT(a_top_code, v2_q && en3 && mid.cmd == CMD_QUANT && !mid.zero_norm && mid.top_hit, out_data_o.code_out == CODE_TOP)

endmodule

`default_nettype wire

/* test/stochastic_log_level_quantizer_test.sv */
// Self-checking testbench for the stochastic log-level quantizer: directed and random transactions.
module stochastic_log_level_quantizer_test;
  import slq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic signed [VAL_W-1:0] FIX_ONE = 32'sh0100_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [NORM_W-1:0] NORM_MAX = '1;
  localparam logic [DRAW_W-1:0] DRAW_MAX = '1;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  slq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  slq_out_t out_data;

  slq_out_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int unsigned stall_left = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  stochastic_log_level_quantizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint level_weight(int j);
    if (j < HALF_LV) begin
      return -(longint'(1) << (TOP_EXP - j));
    end
    return longint'(1) << (j - HALF_LV);
  endfunction

  function automatic logic [CODE_W-1:0] nearest_code(logic signed [VAL_W-1:0] grad,
                                                     logic [NORM_W-1:0] norm,
                                                     logic [DRAW_W-1:0] draw);
    longint scaled, upper, bound;
    logic [127:0] lhs, rhs;
    logic [DRAW_W-1:0] frac;
    int j;
    if (norm == 0) begin
      return (grad >= 0) ? CODE_TOP : CODE_BOT;
    end
    frac = (draw > DRAW_ONE) ? DRAW_ONE : draw;
    scaled = longint'(grad) * (longint'(1) << TOP_EXP);
    for (j = 0; j < LEVELS - 1; j++) begin
      upper = level_weight(j + 1);
      bound = upper * longint'(norm);
      if (scaled <= bound) begin
        lhs = 128'(upper - level_weight(j)) * 128'(norm) * 128'(frac);
        rhs = 128'(bound - scaled) * 128'(DRAW_ONE);
        return CODE_W'((lhs > rhs) ? j + 1 : j);
      end
    end
    return CODE_TOP;
  endfunction

  function automatic logic signed [VAL_W-1:0] level_value(logic [CODE_W-1:0] code,
                                                         logic [NORM_W-1:0] norm);
    logic [VAL_W-1:0] mag;
    if (int'(code) < HALF_LV) begin
      mag = VAL_W'(norm >> code);
      return -mag;
    end
    mag = VAL_W'(norm >> (LEVELS - 1 - int'(code)));
    return mag;
  endfunction

  function automatic slq_out_t quantizer_result(slq_in_t t);
    slq_out_t r;
    r = '0;
    if (t.cmd == CMD_QUANT) begin
      r.code_out = nearest_code(t.grad_value, t.bucket_norm, t.random_draw);
    end else begin
      r.value_out = level_value(t.level_code, t.bucket_norm);
    end
    r.last_out = t.last_in;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic slq_in_t make_item(slq_cmd_e cmd, logic signed [VAL_W-1:0] grad,
                                        logic [NORM_W-1:0] norm, logic [DRAW_W-1:0] draw,
                                        logic [CODE_W-1:0] code, logic last);
    slq_in_t t;
    t.cmd = cmd;
    t.grad_value = grad;
    t.bucket_norm = norm;
    t.random_draw = draw;
    t.level_code = code;
    t.last_in = last;
    return t;
  endfunction

  function automatic slq_in_t noise_item();
    return make_item(slq_cmd_e'($urandom_range(0, 1)), VAL_W'($urandom()),
                     NORM_W'($urandom()), DRAW_W'($urandom()), CODE_W'($urandom()),
                     1'($urandom()));
  endfunction

  function automatic slq_in_t ratio_item();
    slq_in_t t;
    logic [63:0] span, mag;
    t = noise_item();
    t.cmd = CMD_QUANT;
    t.bucket_norm = NORM_W'($urandom() >> $urandom_range(1, 28));
    span = 64'(t.bucket_norm) >> $urandom_range(0, TOP_EXP);
    case ($urandom_range(0, 5))
      0: mag = span;
      1: mag = span + 1;
      default: mag = (span * 64'($urandom_range(0, 65536))) >> 16;
    endcase
    t.grad_value = $urandom_range(0, 1) ? -VAL_W'(mag) : VAL_W'(mag);
    case ($urandom_range(0, 15))
      0: t.random_draw = '0;
      1: t.random_draw = DRAW_ONE;
      2: t.random_draw = DRAW_W'($urandom_range(1000001, (1 << DRAW_W) - 1));
      default: t.random_draw = DRAW_W'($urandom_range(0, 1000000));
    endcase
    return t;
  endfunction

  task automatic send_transaction(input slq_in_t t);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(quantizer_result(t));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_zero_norm();
    send_transaction(make_item(CMD_QUANT, '0, '0, DRAW_ONE, '0, 1'b0));
    send_transaction(make_item(CMD_QUANT, VAL_MIN, '0, '0, '1, 1'b1));
  endtask

  task automatic test_ratio_edges();
    send_transaction(make_item(CMD_QUANT, FIX_ONE, FIX_ONE, '0, '0, 1'b0));
    send_transaction(make_item(CMD_QUANT, FIX_ONE, FIX_ONE, DRAW_ONE, '0, 1'b1));
    send_transaction(make_item(CMD_QUANT, -FIX_ONE, FIX_ONE, DRAW_ONE, '0, 1'b0));
    send_transaction(make_item(CMD_QUANT, FIX_ONE >>> TOP_EXP, FIX_ONE, '0, '0, 1'b0));
    send_transaction(make_item(CMD_QUANT, VAL_MAX, NORM_W'(1), '0, '0, 1'b0));
    send_transaction(make_item(CMD_QUANT, VAL_MIN, NORM_W'(1), DRAW_MAX, '0, 1'b1));
    send_transaction(make_item(CMD_QUANT, -(FIX_ONE >>> 1), FIX_ONE, DRAW_MAX, '0, 1'b0));
    send_transaction(make_item(CMD_QUANT, VAL_MIN, NORM_MAX, '0, '0, 1'b1));
  endtask

  task automatic test_dequantize_codes();
    for (int c = 0; c < LEVELS; c++) begin
      send_transaction(make_item(CMD_DEQUANT, VAL_W'($urandom()),
                                 (c % 2 == 0) ? NORM_MAX : NORM_W'($urandom()),
                                 DRAW_W'($urandom()), CODE_W'(c), 1'(c)));
    end
  endtask

  task automatic test_random_quantize(input int count);
    for (int i = 0; i < count; i++) begin
      send_transaction(($urandom_range(0, 9) == 0) ? noise_item() : ratio_item());
    end
  endtask

  task automatic test_random_mixed(input int count);
    for (int i = 0; i < count; i++) begin
      tx_idle_on = (i % 200) >= 60;
      rx_idle_on = (i % 300) >= 100;
      send_transaction(($urandom_range(0, 1) == 0) ? ratio_item() : noise_item());
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    slq_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, got %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.code_out !== want.code_out) begin
          $display("%0t: code_out expected %0d, got %0d", $time, want.code_out,
                   out_data.code_out);
          mismatches++;
        end
        if (out_data.value_out !== want.value_out) begin
          $display("%0t: value_out expected %0d, got %0d", $time, want.value_out,
                   out_data.value_out);
          mismatches++;
        end
        if (out_data.last_out !== want.last_out) begin
          $display("%0t: last_out expected %0b, got %0b", $time, want.last_out,
                   out_data.last_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_norm();
    test_ratio_edges();
    test_dequantize_codes();
    wait_for_results();
    test_random_quantize(700);
    wait_for_results();
    test_random_mixed(650);
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
